// ----- hw/rtl/fwsh_pkg.sv -----
// fwsh_pkg: shared constants, register codes and the shaper curve ROM
// for the fuzz waveshaper. The curve ROM is built at elaboration time.
// No dependencies.
package fwsh_pkg;

  // Curve table size, power of two in 64..4096
  localparam int TABLE_ENTRIES = 256;
  localparam int TABLE_BITS    = $clog2(TABLE_ENTRIES);
  // Fraction bits left below the table index (position is |u| * N / 2^30)
  localparam int FRAC_BITS     = 30 - TABLE_BITS;
  // Width of the table index before clamping (33-bit product)
  localparam int IDX_W         = 33 - FRAC_BITS;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;

  // Configuration register indexes
  localparam logic REG_DRIVE_GAIN = 1'b0;
  localparam logic REG_LEVEL_GAIN = 1'b1;

  localparam logic [GAIN_W-1:0] DRIVE_GAIN_RST = 16'd4096;
  localparam logic [GAIN_W-1:0] LEVEL_GAIN_RST = 16'd16384;

  localparam logic [63:0] Q30_ONE  = 64'd1 << 30;
  localparam logic [63:0] Q30_MASK = Q30_ONE - 64'd1;

  typedef logic [SAMPLE_W-1:0] rom_t [TABLE_ENTRIES];

  // Unsigned 64-bit quotient, shift and subtract, truncated
  function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] b);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int j = 63; j >= 0; j--) begin
      rem = {rem[63:0], a[j]};
      if (rem >= {1'b0, b}) begin
        rem  = rem - {1'b0, b};
        q[j] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-f), f in [0,1], Q30, 25-term Taylor series
  function automatic logic [63:0] exp_neg_frac(logic [63:0] f);
    longint      sum;
    logic [63:0] term;
    logic        odd;
    sum  = longint'(Q30_ONE);
    term = Q30_ONE;
    odd  = 1'b1;
    for (int n = 1; n <= 24; n++) begin
      term = udiv64((term * f) >> 30, 64'(n));
      if (odd) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
      odd = !odd;
    end
    if (sum < 0) begin
      sum = 0;
    end
    return 64'(sum);
  endfunction

  // exp(-y), y in Q30 of any size
  function automatic logic [63:0] exp_neg(logic [63:0] y);
    logic [63:0] whole;
    logic [63:0] r;
    logic [63:0] e1;
    whole = y >> 30;
    r     = exp_neg_frac(y & Q30_MASK);
    e1    = exp_neg_frac(Q30_ONE);
    for (int k = 0; k < 64; k++) begin
      if (64'(k) < whole) begin
        r = (r * e1) >> 30;
      end
    end
    return r;
  endfunction

  // Curve points: 1 - exp(-0.7 * tanh(x)), x = 8*i/N, Q1.15 rounded
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] two_x;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] t;
    logic [63:0] y;
    logic [63:0] g;
    logic [63:0] f;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      // 2x in Q30 is i * 2^34 / N, N a power of two
      two_x = 64'(i) << (34 - TABLE_BITS);
      e     = exp_neg(two_x);
      num   = (Q30_ONE > e) ? (Q30_ONE - e) : 64'd0;
      t     = udiv64(num << 30, Q30_ONE + e);
      y     = udiv64(t * 64'd7, 64'd10);
      g     = exp_neg(y);
      f     = (Q30_ONE > g) ? (Q30_ONE - g) : 64'd0;
      rom[i] = SAMPLE_W'((f * 64'd32768 + (Q30_ONE >> 1)) >> 30);
    end
    return rom;
  endfunction

  localparam rom_t CURVE_ROM = build_rom();

endpackage

// ----- hw/rtl/fuzz_waveshaper.sv -----
// fuzz_waveshaper: pipelined 1-exp(-0.7*tanh) soft-clip waveshaper, top level.
// Depends on fwsh_pkg (curve ROM, register codes, widths).
//
// Usage
//   Input channel: in_valid / in_ready / sample_in (signed Q1.15). One
//   transaction carries one sample.
//   Output channel: out_valid / out_ready / sample_out (signed Q1.15). One
//   transaction per input sample, in input order.
//   Config port: cfg_wen / cfg_index / cfg_data. Index 0 is drive_gain
//   (unsigned Q4.12), index 1 is level_gain (unsigned Q2.14). Writes land at
//   the clock edge with cfg_wen high; write only while the pipe is empty.
// Timing
//   Six register stages: abs, drive multiply, ROM lookup, interpolation
//   multiply, level multiply, round/saturate into the output register.
//   Throughput is one sample per cycle while out_ready is high; no stage
//   loops back, so nothing holds an item longer.
// Reset and stall
//   rst (synchronous) empties the pipe and restores unity gains. Each stage
//   moves when the next is empty or moving, so bubbles close up. With
//   out_ready low and all six stages full, in_ready drops; nothing is lost.
module fuzz_waveshaper (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [15:0]             sample_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [15:0]             sample_out,
  input  logic                           cfg_wen,
  input  logic                           cfg_index,
  input  logic [fwsh_pkg::GAIN_W-1:0]    cfg_data
);

  localparam int NSTAGE = 6;
  localparam int F      = fwsh_pkg::FRAC_BITS;
  localparam int TB     = fwsh_pkg::TABLE_BITS;
  localparam int ACC_W  = F + 18;
  localparam logic [fwsh_pkg::IDX_W-1:0] IDX_LAST =
    fwsh_pkg::IDX_W'(fwsh_pkg::TABLE_ENTRIES - 1);
  localparam logic [ACC_W-1:0] ROUND_INTERP = ACC_W'(64'd1 << (F - 1));

  // Config registers
  logic [15:0] drive_gain;
  logic [15:0] level_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_gain <= fwsh_pkg::DRIVE_GAIN_RST;
      level_gain <= fwsh_pkg::LEVEL_GAIN_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        fwsh_pkg::REG_DRIVE_GAIN: drive_gain <= cfg_data;
        fwsh_pkg::REG_LEVEL_GAIN: level_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-stage valid bits and advance enables
  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] adv;

  always_comb begin
    adv[NSTAGE-1] = !vld[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[NSTAGE-1];

  // Stage 1: sign and magnitude (-32768 gives 32768)
  logic        s1_neg;
  logic [16:0] s1_mag;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_neg <= sample_in[15];
      s1_mag <= sample_in[15] ? (17'd0 - {sample_in[15], sample_in})
                              : {1'b0, sample_in};
    end
  end

  // Stage 2: |u| = |x| * drive, Q.27 magnitude
  logic        s2_neg;
  logic [32:0] s2_p;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_neg <= s1_neg;
      s2_p   <= s1_mag * drive_gain;
    end
  end

  // Stage 3: table lookup; beyond the last interval the curve is flat
  logic [fwsh_pkg::IDX_W-1:0] idx;
  logic [TB-1:0]              idx_lo;
  logic [TB-1:0]              idx_hi;
  logic                       beyond;
  logic [15:0]                pt_a;
  logic [15:0]                pt_b;

  always_comb begin
    idx    = s2_p[32:F];
    idx_lo = idx[TB-1:0];
    idx_hi = idx_lo + 1'b1;
    beyond = idx >= IDX_LAST;
    pt_a   = fwsh_pkg::CURVE_ROM[idx_lo];
    pt_b   = fwsh_pkg::CURVE_ROM[idx_hi];
  end

  logic               s3_neg;
  logic [15:0]        s3_a;
  logic signed [16:0] s3_diff;
  logic [F-1:0]       s3_fr;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_neg <= s2_neg;
      if (beyond) begin
        s3_a    <= fwsh_pkg::CURVE_ROM[fwsh_pkg::TABLE_ENTRIES-1];
        s3_diff <= '0;
        s3_fr   <= '0;
      end else begin
        s3_a    <= pt_a;
        s3_diff <= $signed({1'b0, pt_b}) - $signed({1'b0, pt_a});
        s3_fr   <= s2_p[F-1:0];
      end
    end
  end

  // Stage 4: a + (b-a)*frac, rounded
  logic signed [ACC_W-1:0] interp_mul;
  logic [ACC_W-1:0]        interp_acc;

  always_comb begin
    interp_mul = s3_diff * $signed({1'b0, s3_fr});
    interp_acc = {2'b00, s3_a, {F{1'b0}}} + ACC_W'(interp_mul) + ROUND_INTERP;
  end

  logic        s4_neg;
  logic [15:0] s4_shaped;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_neg    <= s3_neg;
      s4_shaped <= interp_acc[F+15:F];
    end
  end

  // Stage 5: level gain
  logic        s5_neg;
  logic [31:0] s5_prod;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s5_neg  <= s4_neg;
      s5_prod <= s4_shaped * level_gain;
    end
  end

  // Stage 6: round, saturate, restore sign
  logic [32:0] lvl_round;
  logic [18:0] mag_out;
  logic [15:0] res;

  always_comb begin
    lvl_round = {1'b0, s5_prod} + 33'd8192;
    mag_out   = lvl_round[32:14];
    if (mag_out == '0) begin
      res = '0;
    end else if (s5_neg) begin
      res = (mag_out > 19'd32768) ? 16'h8000 : (16'd0 - mag_out[15:0]);
    end else begin
      res = (mag_out > 19'd32767) ? 16'h7fff : mag_out[15:0];
    end
  end

  logic s6_neg;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s6_neg     <= s5_neg;
      sample_out <= res;
    end
  end

  // Back-pressure only comes from a held result at the output
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without output stall");

  // An accepted sample occupies stage 1 in the next cycle
  a_accept_fill: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> vld[0])
    else $error("accepted sample lost at stage 1");

  // Positive inputs never produce negative outputs
  a_sign_keep: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !s6_neg) |-> !sample_out[15])
    else $error("positive sample gave negative output");

endmodule
